### src/arc_pkg.sv
package arc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AluW   = 42;  // holds 510*span + span with a sign bit
  localparam int unsigned LevelW = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DivSteps = LevelW;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [2:0] MODE_BLUE_RED     = 3'd0;
  localparam logic [2:0] MODE_GREEN_MAGENTA = 3'd1;
  localparam logic [2:0] MODE_WHITE_RED    = 3'd2;
  localparam logic [2:0] MODE_GREY_RED     = 3'd3;
  localparam logic [2:0] MODE_RAINBOW      = 3'd4;
  localparam logic [2:0] MODE_SOLID        = 3'd5;

  localparam logic [2:0] REG_AXIS  = 3'd0;
  localparam logic [2:0] REG_MODE  = 3'd1;
  localparam logic [2:0] REG_RED   = 3'd2;
  localparam logic [2:0] REG_GREEN = 3'd3;
  localparam logic [2:0] REG_BLUE  = 3'd4;

  localparam logic [LevelW-1:0] LEVEL_MID = 8'd128;
  localparam logic [LevelW-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_LO,
    S_SCAN_HI,
    S_SPAN,
    S_DIFF,
    S_CMP,
    S_NUM_A,
    S_NUM_B,
    S_DIV,
    S_DONE
  } arc_state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } arc_alu_op_e;

  typedef struct packed {
    logic [1:0]       axis_select;
    logic [2:0]       color_mode;
    logic [ChanW-1:0] solid_red;
    logic [ChanW-1:0] solid_green;
    logic [ChanW-1:0] solid_blue;
  } arc_cfg_t;

  function automatic logic [AluW-1:0] sext(input logic [CoordW-1:0] v);
    return {{(AluW-CoordW){v[CoordW-1]}}, v};
  endfunction

endpackage

### src/arc_if.sv
interface arc_item_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic                             first_point;
  logic signed [arc_pkg::CoordW-1:0] coord_x;
  logic signed [arc_pkg::CoordW-1:0] coord_y;
  logic signed [arc_pkg::CoordW-1:0] coord_z;

  modport source (output valid, req_type, first_point, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, req_type, first_point, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface arc_result_if;
  logic                       valid;
  logic                       ready;
  logic [arc_pkg::ChanW-1:0]  red;
  logic [arc_pkg::ChanW-1:0]  green;
  logic [arc_pkg::ChanW-1:0]  blue;
  logic [arc_pkg::LevelW-1:0] level;

  modport source (output valid, red, green, blue, level, input ready);
  modport sink   (input valid, red, green, blue, level, output ready);
endinterface

### src/axis_range_colormap.sv
// channel   | dir | payload                                      | handshake
// item_i    | in  | req_type, first_point, coord_x/y/z (Q16.16)  | valid/ready
// result_o  | out | red, green, blue, level                      | valid/ready
// apb       | in  | axis_select, color_mode, solid_red/green/blue | psel/penable
//
// Scan transaction: state S_SCAN_LO, then S_SCAN_HI unless first_point is set.
// Colour transaction: S_SPAN, S_DIFF, ending there for a flat range or a point at or
// below the low end; S_CMP ends it for a point at or above the high end; else S_NUM_A,
// S_NUM_B and the 8 steps of the restoring divide on the shared 42-bit adder.
// A finished result sits in the output register; the next item is taken meanwhile.
// Reset clears the range to zero and the registers to their defaults.
module axis_range_colormap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [arc_pkg::AddrW-1:0] paddr,
  input  logic [arc_pkg::DataW-1:0] pwdata,
  output logic [arc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  arc_item_if.sink                  item_i,
  arc_result_if.source              result_o
);

  arc_pkg::arc_cfg_t            cfg;
  logic                         res_valid;
  logic                         res_ready;
  logic [arc_pkg::LevelW-1:0]   lvl;
  logic [arc_pkg::ChanW-1:0]    red, green, blue;

  logic                         out_valid_q;
  logic [arc_pkg::ChanW-1:0]    red_q, green_q, blue_q;
  logic [arc_pkg::LevelW-1:0]   level_q;

  arc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  arc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .level_o     (lvl)
  );

  arc_cmap u_cmap (
    .level_i (lvl),
    .cfg_i   (cfg),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      level_q <= lvl;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.red   = red_q;
  assign result_o.green = green_q;
  assign result_o.blue  = blue_q;
  assign result_o.level = level_q;

endmodule

### src/arc_regs.sv
module arc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arc_pkg::AddrW-1:0]   paddr,
  input  logic [arc_pkg::DataW-1:0]   pwdata,
  output logic [arc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output arc_pkg::arc_cfg_t           cfg_o
);

  arc_pkg::arc_cfg_t cfg_q;
  logic [2:0]        idx;
  logic              wr_en;

  assign idx    = paddr[arc_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_select <= arc_pkg::AXIS_X;
      cfg_q.color_mode  <= arc_pkg::MODE_BLUE_RED;
      cfg_q.solid_red   <= 8'd255;
      cfg_q.solid_green <= 8'd0;
      cfg_q.solid_blue  <= 8'd0;
    end else if (wr_en) begin
      unique case (idx)
        arc_pkg::REG_AXIS:  cfg_q.axis_select <= pwdata[1:0];
        arc_pkg::REG_MODE:  cfg_q.color_mode  <= pwdata[2:0];
        arc_pkg::REG_RED:   cfg_q.solid_red   <= pwdata[arc_pkg::ChanW-1:0];
        arc_pkg::REG_GREEN: cfg_q.solid_green <= pwdata[arc_pkg::ChanW-1:0];
        arc_pkg::REG_BLUE:  cfg_q.solid_blue  <= pwdata[arc_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      arc_pkg::REG_AXIS:  prdata = {30'd0, cfg_q.axis_select};
      arc_pkg::REG_MODE:  prdata = {29'd0, cfg_q.color_mode};
      arc_pkg::REG_RED:   prdata = {24'd0, cfg_q.solid_red};
      arc_pkg::REG_GREEN: prdata = {24'd0, cfg_q.solid_green};
      arc_pkg::REG_BLUE:  prdata = {24'd0, cfg_q.solid_blue};
      default:            prdata = '0;
    endcase
  end

endmodule

### src/arc_alu.sv
module arc_alu (
  input  logic [arc_pkg::AluW-1:0] a_i,
  input  logic [arc_pkg::AluW-1:0] b_i,
  input  arc_pkg::arc_alu_op_e     op_i,
  output logic [arc_pkg::AluW-1:0] res_o
);

  always_comb begin
    case (op_i)
      arc_pkg::ALU_ADD: res_o = a_i + b_i;
      arc_pkg::ALU_SUB: res_o = a_i - b_i;
      default:          res_o = a_i - b_i;
    endcase
  end

endmodule

### src/arc_cmap.sv
module arc_cmap (
  input  logic [arc_pkg::LevelW-1:0] level_i,
  input  arc_pkg::arc_cfg_t          cfg_i,
  output logic [arc_pkg::ChanW-1:0]  red_o,
  output logic [arc_pkg::ChanW-1:0]  green_o,
  output logic [arc_pkg::ChanW-1:0]  blue_o
);

  logic [arc_pkg::ChanW-1:0] inv;
  logic [arc_pkg::ChanW-1:0] dbl;
  logic                      hi_half;
  logic                      above_mid;

  assign inv       = arc_pkg::LEVEL_MAX - level_i;
  // 2v below the midpoint, 2(v-128) at or above it
  assign dbl       = {level_i[arc_pkg::LevelW-2:0], 1'b0};
  assign hi_half   = level_i[arc_pkg::LevelW-1];
  assign above_mid = level_i > arc_pkg::LEVEL_MID;

  always_comb begin
    case (cfg_i.color_mode)
      arc_pkg::MODE_BLUE_RED: begin
        red_o = level_i; green_o = '0; blue_o = inv;
      end
      arc_pkg::MODE_GREEN_MAGENTA: begin
        red_o = level_i; green_o = inv; blue_o = level_i;
      end
      arc_pkg::MODE_WHITE_RED: begin
        red_o = arc_pkg::LEVEL_MAX; green_o = inv; blue_o = inv;
      end
      arc_pkg::MODE_GREY_RED: begin
        if (above_mid) begin
          red_o = arc_pkg::LEVEL_MAX; green_o = '0; blue_o = '0;
        end else begin
          red_o = arc_pkg::LEVEL_MID; green_o = arc_pkg::LEVEL_MID;
          blue_o = arc_pkg::LEVEL_MID;
        end
      end
      arc_pkg::MODE_SOLID: begin
        red_o = cfg_i.solid_red; green_o = cfg_i.solid_green; blue_o = cfg_i.solid_blue;
      end
      default: begin
        // rainbow; unused mode codes land here too
        red_o   = hi_half ? dbl : '0;
        green_o = hi_half ? (arc_pkg::LEVEL_MAX - dbl) : dbl;
        blue_o  = hi_half ? '0 : (arc_pkg::LEVEL_MAX - dbl);
      end
    endcase
  end

endmodule

### src/arc_seq.sv
module arc_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  arc_pkg::arc_cfg_t           cfg_i,
  arc_item_if.sink                    item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [arc_pkg::LevelW-1:0]  level_o
);

  localparam int unsigned AluW   = arc_pkg::AluW;
  localparam int unsigned CoordW = arc_pkg::CoordW;
  localparam int unsigned CntW   = $clog2(arc_pkg::DivSteps);

  arc_pkg::arc_state_e state_q, state_d;

  logic signed [CoordW-1:0] coord_q;
  logic                     first_q;
  logic signed [CoordW-1:0] low_q;
  logic signed [CoordW-1:0] high_q;
  logic [CoordW:0]          span_q;
  logic [AluW-1:0]          acc_q;
  logic [AluW-1:0]          dv_q;
  logic [arc_pkg::LevelW-1:0] lvl_q;
  logic [CntW-1:0]          cnt_q;

  logic [CoordW-1:0]        coord_sel;
  logic                     accept;
  logic [AluW-1:0]          alu_a;
  logic [AluW-1:0]          alu_b;
  arc_pkg::arc_alu_op_e     alu_op;
  logic [AluW-1:0]          alu_res;
  logic                     alu_neg;
  logic                     alu_zero;
  logic [AluW-1:0]          span_ext;

  assign item_i.ready = (state_q == arc_pkg::S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign res_valid_o  = (state_q == arc_pkg::S_DONE);
  assign level_o      = lvl_q;
  assign span_ext     = {{(AluW-CoordW-1){1'b0}}, span_q};
  assign alu_neg      = alu_res[AluW-1];
  assign alu_zero     = (alu_res == '0);

  always_comb begin
    case (cfg_i.axis_select)
      arc_pkg::AXIS_X: coord_sel = item_i.coord_x;
      arc_pkg::AXIS_Y: coord_sel = item_i.coord_y;
      default:         coord_sel = item_i.coord_z;
    endcase
  end

  // operand steering for the shared adder
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = arc_pkg::ALU_SUB;
    case (state_q)
      arc_pkg::S_SCAN_LO: begin
        alu_a = arc_pkg::sext(coord_q); alu_b = arc_pkg::sext(low_q);
      end
      arc_pkg::S_SCAN_HI: begin
        alu_a = arc_pkg::sext(high_q); alu_b = arc_pkg::sext(coord_q);
      end
      arc_pkg::S_SPAN: begin
        alu_a = arc_pkg::sext(high_q); alu_b = arc_pkg::sext(low_q);
      end
      arc_pkg::S_DIFF: begin
        alu_a = arc_pkg::sext(coord_q); alu_b = arc_pkg::sext(low_q);
      end
      arc_pkg::S_CMP: begin
        alu_a = acc_q; alu_b = span_ext;
      end
      arc_pkg::S_NUM_A: begin
        // diff*510 = diff*512 - diff*2
        alu_a = {acc_q[AluW-10:0], 9'd0}; alu_b = {acc_q[AluW-2:0], 1'b0};
      end
      arc_pkg::S_NUM_B: begin
        alu_a = acc_q; alu_b = span_ext; alu_op = arc_pkg::ALU_ADD;
      end
      arc_pkg::S_DIV: begin
        alu_a = acc_q; alu_b = dv_q;
      end
      default: ;
    endcase
  end

  arc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arc_pkg::S_IDLE:    if (accept) begin
                            state_d = item_i.req_type ? arc_pkg::S_SPAN : arc_pkg::S_SCAN_LO;
                          end
      arc_pkg::S_SCAN_LO: state_d = first_q ? arc_pkg::S_IDLE : arc_pkg::S_SCAN_HI;
      arc_pkg::S_SCAN_HI: state_d = arc_pkg::S_IDLE;
      arc_pkg::S_SPAN:    state_d = arc_pkg::S_DIFF;
      arc_pkg::S_DIFF:    if (span_q == '0 || alu_neg || alu_zero) begin
                            state_d = arc_pkg::S_DONE;
                          end else begin
                            state_d = arc_pkg::S_CMP;
                          end
      arc_pkg::S_CMP:     state_d = alu_neg ? arc_pkg::S_NUM_A : arc_pkg::S_DONE;
      arc_pkg::S_NUM_A:   state_d = arc_pkg::S_NUM_B;
      arc_pkg::S_NUM_B:   state_d = arc_pkg::S_DIV;
      arc_pkg::S_DIV:     if (cnt_q == '0) begin
                            state_d = arc_pkg::S_DONE;
                          end
      arc_pkg::S_DONE:    if (res_ready_i) begin
                            state_d = arc_pkg::S_IDLE;
                          end
      default:            state_d = arc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // tracked range is architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (state_q == arc_pkg::S_SCAN_LO) begin
      if (first_q) begin
        low_q  <= coord_q;
        high_q <= coord_q;
      end else if (alu_neg) begin
        low_q  <= coord_q;
      end
    end else if (state_q == arc_pkg::S_SCAN_HI && alu_neg) begin
      high_q <= coord_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      coord_q  <= coord_sel;
      first_q  <= item_i.first_point;
    end
    case (state_q)
      arc_pkg::S_SPAN:  span_q <= alu_res[CoordW:0];
      arc_pkg::S_DIFF: begin
        acc_q <= alu_res;
        lvl_q <= '0;
      end
      arc_pkg::S_CMP:   if (!alu_neg) begin
                          lvl_q <= arc_pkg::LEVEL_MAX;
                        end
      arc_pkg::S_NUM_A: acc_q <= alu_res;
      arc_pkg::S_NUM_B: begin
        // restoring divide by 2*span, top quotient bit first
        acc_q <= alu_res;
        dv_q  <= {{(AluW-CoordW-9){1'b0}}, span_q, 8'd0};
        cnt_q <= CntW'(arc_pkg::DivSteps - 1);
        lvl_q <= '0;
      end
      arc_pkg::S_DIV: begin
        if (!alu_neg) begin
          acc_q <= alu_res;
        end
        dv_q  <= {1'b0, dv_q[AluW-1:1]};
        cnt_q <= cnt_q - 1'b1;
        lvl_q <= {lvl_q[arc_pkg::LevelW-2:0], !alu_neg};
      end
      default: ;
    endcase
  end

  a_range_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == arc_pkg::S_IDLE |-> low_q <= high_q)
    else $error("tracked range inverted");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != arc_pkg::S_IDLE)
    else $error("ready while a transaction is in flight");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arc_pkg::S_DIV && cnt_q == '0) |=>
      acc_q < {{(AluW-CoordW-2){1'b0}}, span_q, 1'b0})
    else $error("divide remainder not below divisor");

  a_flat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arc_pkg::S_DONE && span_q == '0) |-> lvl_q == '0)
    else $error("non-zero level on a flat range");

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 500_000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned PHASES          = 16;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned DIR_ROWS        = 25;

  localparam logic REQ_SCAN   = 1'b0;
  localparam logic REQ_COLOUR = 1'b1;

  localparam logic [arc_pkg::CoordW-1:0] CMIN = 32'h8000_0000;
  localparam logic [arc_pkg::CoordW-1:0] CMAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                       req_type;
    logic                       first_point;
    logic [arc_pkg::CoordW-1:0] x;
    logic [arc_pkg::CoordW-1:0] y;
    logic [arc_pkg::CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [arc_pkg::ChanW-1:0]  red;
    logic [arc_pkg::ChanW-1:0]  green;
    logic [arc_pkg::ChanW-1:0]  blue;
    logic [arc_pkg::LevelW-1:0] level;
  } colour_t;

  typedef struct packed {
    point_t  point;
    logic    known;
    colour_t colour;
  } directed_row_t;

  // blue-red mode at the two ends of the scale
  localparam colour_t BR_LOW  = '{8'd0, 8'd0, 8'd255, 8'd0};
  localparam colour_t BR_HIGH = '{8'd255, 8'd0, 8'd0, 8'd255};
  localparam colour_t NONE    = '0;

  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    '{'{REQ_COLOUR, 1'b0, 32'd1234, CMAX, CMIN}, 1'b1, BR_LOW},          // flat after reset
    '{'{REQ_SCAN, 1'b0, 32'hFF9C_0000, 32'd0, 32'd0}, 1'b0, NONE},      // widens zero range
    '{'{REQ_COLOUR, 1'b0, 32'd0, CMIN, CMAX}, 1'b1, BR_HIGH},
    '{'{REQ_COLOUR, 1'b0, 32'hFF9C_0000, 32'd0, 32'd0}, 1'b1, BR_LOW},
    '{'{REQ_COLOUR, 1'b0, 32'hFFCE_0000, CMAX, CMAX}, 1'b0, NONE},      // half way
    '{'{REQ_SCAN, 1'b1, CMIN, CMAX, 32'd0}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, CMIN, 32'd0, CMIN}, 1'b1, BR_LOW},
    '{'{REQ_SCAN, 1'b0, CMAX, CMIN, CMAX}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, CMIN, CMAX, CMIN}, 1'b1, BR_LOW},
    '{'{REQ_COLOUR, 1'b0, CMAX, CMIN, CMAX}, 1'b1, BR_HIGH},
    '{'{REQ_COLOUR, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0}, 1'b0, NONE},   // first ignored
    '{'{REQ_COLOUR, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF}, 1'b0, NONE},
    '{'{REQ_SCAN, 1'b1, 32'd0, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, NONE},
    '{'{REQ_SCAN, 1'b0, 32'd256, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b1, BR_LOW},  // below range
    '{'{REQ_COLOUR, 1'b0, 32'd300, 32'd0, 32'd0}, 1'b1, BR_HIGH},       // above range
    '{'{REQ_COLOUR, 1'b0, 32'd128, CMIN, CMAX}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b1, 32'd1, CMAX, CMIN}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, 32'd255, 32'd0, 32'd0}, 1'b0, NONE},
    '{'{REQ_SCAN, 1'b1, 32'd7, 32'd0, 32'd0}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, 32'd7, 32'd0, 32'd0}, 1'b1, BR_LOW},          // flat range
    '{'{REQ_COLOUR, 1'b0, 32'hFFFF_FFFB, 32'd0, 32'd0}, 1'b1, BR_LOW},
    '{'{REQ_SCAN, 1'b1, 32'd0, 32'd0, 32'd0}, 1'b0, NONE},
    '{'{REQ_SCAN, 1'b0, 32'd2, 32'd0, 32'd0}, 1'b0, NONE},
    '{'{REQ_COLOUR, 1'b0, 32'd1, 32'd0, 32'd0}, 1'b0, NONE}             // exact half rounds up
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [arc_pkg::AddrW-1:0] paddr;
  logic [arc_pkg::DataW-1:0] pwdata;
  logic [arc_pkg::DataW-1:0] prdata;
  logic                      pready;

  arc_item_if   item_bus ();
  arc_result_if colour_bus ();

  axis_range_colormap dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_bus),
    .result_o (colour_bus)
  );

  // local copy of the block's state
  arc_pkg::arc_cfg_t  cfg_now = '{arc_pkg::AXIS_X, arc_pkg::MODE_BLUE_RED,
                                  8'd255, 8'd0, 8'd0};
  logic signed [31:0] range_lo = '0;
  logic signed [31:0] range_hi = '0;

  colour_t colour_due [$];
  int      items_taken  = 0;
  int      colours_seen = 0;
  int      mismatches   = 0;
  int      cycles       = 0;
  bit      idling_on    = 1'b1;
  bit      hold_request = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // Applies a scan point to the tracked range; returns 1 with the colour for colour items.
  function automatic bit predict_point(input point_t p, output colour_t c);
    logic signed [arc_pkg::CoordW-1:0] coord;
    longint                            span;
    longint                            diff;
    longint                            quot;
    int                                v;
    case (cfg_now.axis_select)
      arc_pkg::AXIS_X: coord = p.x;
      arc_pkg::AXIS_Y: coord = p.y;
      default:         coord = p.z;  // code 3 behaves as z
    endcase
    c = '0;
    if (p.req_type == REQ_SCAN) begin
      if (p.first_point) begin
        range_lo = coord;
        range_hi = coord;
      end else begin
        if (coord < range_lo) range_lo = coord;
        if (coord > range_hi) range_hi = coord;
      end
      return 1'b0;
    end
    span = longint'(range_hi) - longint'(range_lo);
    diff = longint'(coord) - longint'(range_lo);
    if (span <= 0 || diff <= 0) begin
      v = 0;
    end else if (diff >= span) begin
      v = 255;
    end else begin
      quot = (diff * 510 + span) / (span * 2);
      v = (quot > 255) ? 255 : int'(quot);
    end
    c.level = v[7:0];
    case (cfg_now.color_mode)
      arc_pkg::MODE_BLUE_RED: begin
        c.red = v[7:0]; c.green = 8'd0; c.blue = 8'(255 - v);
      end
      arc_pkg::MODE_GREEN_MAGENTA: begin
        c.red = v[7:0]; c.green = 8'(255 - v); c.blue = v[7:0];
      end
      arc_pkg::MODE_WHITE_RED: begin
        c.red = 8'd255; c.green = 8'(255 - v); c.blue = 8'(255 - v);
      end
      arc_pkg::MODE_GREY_RED: begin
        if (v > 128) begin
          c.red = 8'd255; c.green = 8'd0; c.blue = 8'd0;
        end else begin
          c.red = 8'd128; c.green = 8'd128; c.blue = 8'd128;
        end
      end
      arc_pkg::MODE_SOLID: begin
        c.red = cfg_now.solid_red; c.green = cfg_now.solid_green; c.blue = cfg_now.solid_blue;
      end
      default: begin  // rainbow, also for the unused codes 6 and 7
        c.red   = (v > 128) ? 8'((v - 128) * 2) : 8'd0;
        c.green = (v < 128) ? 8'(2 * v) : 8'(255 - (v - 128) * 2);
        c.blue  = (v < 128) ? 8'(255 - 2 * v) : 8'd0;
      end
    endcase
    return 1'b1;
  endfunction

  // write then read back, setup and access phase each
  task automatic write_reg(input logic [2:0] idx, input logic [arc_pkg::DataW-1:0] value);
    logic [arc_pkg::DataW-1:0] mask;
    case (idx)
      arc_pkg::REG_AXIS: mask = 32'h3;
      arc_pkg::REG_MODE: mask = 32'h7;
      default:           mask = 32'hFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask))
      flag_mismatch($sformatf("register %0d read %0h, wrote %0h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      arc_pkg::REG_AXIS:  cfg_now.axis_select = value[1:0];
      arc_pkg::REG_MODE:  cfg_now.color_mode  = value[2:0];
      arc_pkg::REG_RED:   cfg_now.solid_red   = value[7:0];
      arc_pkg::REG_GREEN: cfg_now.solid_green = value[7:0];
      default:            cfg_now.solid_blue  = value[7:0];
    endcase
  endtask

  task automatic send_point(input point_t p, input bit known, input colour_t typed);
    colour_t want;
    if (idling_on)
      while ($urandom_range(0, 99) < 37) begin
        item_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    item_bus.valid       <= 1'b1;
    item_bus.req_type    <= p.req_type;
    item_bus.first_point <= p.first_point;
    item_bus.coord_x     <= p.x;
    item_bus.coord_y     <= p.y;
    item_bus.coord_z     <= p.z;
    do @(posedge clk_i); while (!item_bus.ready);
    items_taken++;
    if (predict_point(p, want)) colour_due.push_back(known ? typed : want);
  endtask

  // always waits on the clock before returning, so valid is never lowered and raised in one step
  task automatic drain(input bit settle);
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (colour_due.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : colour_sink
    int hold_left;
    hold_left = 0;
    colour_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        colour_bus.ready <= 1'b0;
      end else begin
        colour_bus.ready <= !idling_on || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  always @(posedge clk_i) begin : colour_check
    colour_t got;
    colour_t want;
    if (rst_ni && colour_bus.valid && colour_bus.ready) begin
      got = '{colour_bus.red, colour_bus.green, colour_bus.blue, colour_bus.level};
      colours_seen++;
      if (colour_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected colour %0d/%0d/%0d level %0d",
                                got.red, got.green, got.blue, got.level));
      end else begin
        want = colour_due.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.level !== want.level)
          flag_mismatch($sformatf("r/g/b/level expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                  want.red, want.green, want.blue, want.level,
                                  got.red, got.green, got.blue, got.level));
      end
    end
  end

  initial begin : stimulus
    point_t      cloud [10];
    point_t      p;
    logic [31:0] base [3];
    logic [31:0] mask;
    int          n;
    int          bits;
    int          target;
    bit          paused;
    item_bus.valid       = 1'b0;
    item_bus.req_type    = 1'b0;
    item_bus.first_point = 1'b0;
    item_bus.coord_x     = '0;
    item_bus.coord_y     = '0;
    item_bus.coord_z     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    paused  = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_point(DIRECTED[i].point, DIRECTED[i].known, DIRECTED[i].colour);
    drain(1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(arc_pkg::REG_AXIS, (ph + ph / 8) % 4);
      write_reg(arc_pkg::REG_MODE, ph % 8);
      if (ph == 5) begin
        write_reg(arc_pkg::REG_RED, 0);
        write_reg(arc_pkg::REG_GREEN, 255);
        write_reg(arc_pkg::REG_BLUE, 0);
      end else if (ph == 13) begin
        write_reg(arc_pkg::REG_RED, 255);
        write_reg(arc_pkg::REG_GREEN, 0);
        write_reg(arc_pkg::REG_BLUE, 255);
      end else begin
        write_reg(arc_pkg::REG_RED, $urandom_range(0, 255));
        write_reg(arc_pkg::REG_GREEN, $urandom_range(0, 255));
        write_reg(arc_pkg::REG_BLUE, $urandom_range(0, 255));
      end
      idling_on = !(ph == 10 || ph == 11);
      if (ph == 3) hold_request = 1'b1;  // output stalls long enough to back up the input
      target = items_taken + ITEMS_PER_PHASE;

      while (items_taken < target) begin
        if (ph == 7 && !paused && items_taken >= target - ITEMS_PER_PHASE / 2) begin
          drain(1'b0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything the fields allow
          p.req_type    = 1'($urandom_range(0, 1));
          p.first_point = 1'($urandom_range(0, 1));
          p.x = $urandom; p.y = $urandom; p.z = $urandom;
          send_point(p, 1'b0, NONE);
        end else begin
          // a scan pass over a small cloud, then a colour pass on its points and near its edges
          n    = $urandom_range(1, 10);
          bits = $urandom_range(0, 32);
          mask = (bits == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - bits));
          foreach (base[k]) base[k] = $urandom;
          for (int i = 0; i < n; i++) begin
            cloud[i].req_type = REQ_SCAN;
            // now and then the pass keeps the previous range
            cloud[i].first_point = (i == 0) && ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 11) == 0) begin
              cloud[i].x = $urandom; cloud[i].y = $urandom; cloud[i].z = $urandom;
            end else begin
              cloud[i].x = base[0] + ($urandom & mask);
              cloud[i].y = base[1] + ($urandom & mask);
              cloud[i].z = base[2] + ($urandom & mask);
            end
            send_point(cloud[i], 1'b0, NONE);
          end
          for (int i = 0; i < n; i++) begin
            p = cloud[i];
            p.req_type    = REQ_COLOUR;
            p.first_point = 1'($urandom_range(0, 1));
            send_point(p, 1'b0, NONE);
            if ($urandom_range(0, 3) == 0) begin
              p.x = base[0] + $urandom_range(0, 7) - 4 + (($urandom_range(0, 1)) ? mask : 0);
              p.y = base[1] + $urandom_range(0, 7) - 4 + (($urandom_range(0, 1)) ? mask : 0);
              p.z = base[2] + $urandom_range(0, 7) - 4 + (($urandom_range(0, 1)) ? mask : 0);
              send_point(p, 1'b0, NONE);
            end
          end
        end
      end
      drain(1'b1);
    end

    $display("Run: %0d transactions over %0d register settings, %0d colours checked.",
             items_taken, PHASES + 1, colours_seen);
    $display("All modes and axis codes, flat and out-of-range points, long output stall; %0d bad.",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
